// ----- sv/first_fit_heap_allocator_assert.svh -----
// assertion macros for the heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and codes of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_REPORT = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADPTR  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] request_bytes;
        logic [15:0] block_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] granted_offset;
        logic [11:0] used_bytes;
        logic [9:0]  used_blocks;
    } rsp_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctrl_status_t;

endpackage

// ----- sv/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// header walk sequencer: reads block headers, splits, merges and sums
// ----------------------------------------------------------------------------
module ffha_ctrl
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  req_t                                  cmd,
    input  logic                                  out_free,
    output ctrl_status_t                          status,
    output rsp_t                                  result,
    output logic                                  rd_en,
    output logic [$clog2(HEAP_BYTES/8)-1:0]       rd_addr,
    input  logic [$clog2(HEAP_BYTES/8)+1-1:0]     rd_data,
    output logic                                  wr_en,
    output logic [$clog2(HEAP_BYTES/8)-1:0]       wr_addr,
    output logic [$clog2(HEAP_BYTES/8)+1-1:0]     wr_data
);

    localparam int GRANULES = HEAP_BYTES / 8;
    localparam int GW = $clog2(GRANULES);
    localparam int PW = GW + 1;
    localparam int EW = GW + 1;
    localparam logic [PW-1:0] END_G = PW'(GRANULES);
    localparam logic [GW-1:0] INIT_SZ = GW'(GRANULES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_RDN  = 3'd3;
    localparam logic [2:0] S_EVN  = 3'd4;
    localparam logic [2:0] S_WR1  = 3'd5;
    localparam logic [2:0] S_WR2  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] need_reg, need_next;
    logic [PW-1:0] obj_reg, obj_next;
    logic          prev_free_reg, prev_free_next;
    logic [GW-1:0] prev_pos_reg, prev_pos_next;
    logic [GW-1:0] prev_sz_reg, prev_sz_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] sum_reg, sum_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic          init_reg, init_next;
    logic          zero_hit_reg, zero_hit_next;
    logic [GW-1:0] wa1_reg, wa1_next;
    logic [EW-1:0] wd1_reg, wd1_next;
    logic [GW-1:0] wa2_reg, wa2_next;
    logic [EW-1:0] wd2_reg, wd2_next;
    rsp_t          res_reg, res_next;

    logic [EW-1:0] hdr;
    logic          h_used;
    logic [PW-1:0] h_sz;
    logic [PW-1:0] adv_pos;
    logic [16:0]   need_b;
    logic [31:0]   need_g;
    logic [31:0]   obj_g;
    logic          alloc_bad;
    logic          free_bad;
    logic [PW-1:0] split_pos;
    logic [PW-1:0] split_sz;
    logic [PW-1:0] base_acc;
    logic [31:0]   grant_b;
    logic [31:0]   bytes_b;
    logic [31:0]   cnt_w;

    // entry 0 reads as the reset block until it is first written
    assign hdr     = zero_hit_reg ? {INIT_SZ, 1'b0} : rd_data;
    assign h_used  = hdr[0];
    assign h_sz    = {1'b0, hdr[EW-1:1]};
    assign adv_pos = pos_reg + PW'(1) + h_sz;

    assign need_b    = {1'b0, cmd.request_bytes} + 17'd7;
    assign need_g    = 32'(need_b[16:3]);
    assign alloc_bad = (cmd.request_bytes == 16'd0) || (need_g + 32'd1 > 32'(GRANULES));
    assign obj_g     = 32'(cmd.block_offset[15:3]) - 32'd1;
    assign free_bad  = (cmd.block_offset < 16'd8) || (cmd.block_offset[2:0] != 3'd0)
                       || (obj_g >= 32'(GRANULES));

    assign split_pos = pos_reg + PW'(1) + need_reg;
    assign split_sz  = h_sz - PW'(1) - need_reg;
    assign base_acc  = (prev_free_reg ? ({1'b0, prev_sz_reg} + PW'(1)) : PW'(0)) + h_sz;
    assign grant_b   = (32'(pos_reg) + 32'd1) << 3;
    assign bytes_b   = 32'(sum_reg) << 3;
    assign cnt_w     = 32'(cnt_reg);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        need_next      = need_reg;
        obj_next       = obj_reg;
        prev_free_next = prev_free_reg;
        prev_pos_next  = prev_pos_reg;
        prev_sz_next   = prev_sz_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        init_next      = init_reg;
        wa1_next       = wa1_reg;
        wd1_next       = wd1_reg;
        wa2_next       = wa2_reg;
        wd2_next       = wd2_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = pos_reg[GW-1:0];
        wr_en          = 1'b0;
        wr_addr        = wa2_reg;
        wr_data        = wd2_reg;
        status.idle    = (state_reg == S_IDLE);
        status.done    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next      = cmd.mode;
                    pos_next       = '0;
                    need_next      = PW'(need_g);
                    obj_next       = PW'(obj_g);
                    prev_free_next = 1'b0;
                    sum_next       = '0;
                    cnt_next       = '0;
                    res_next       = '0;
                    state_next     = S_RD;
                    case (cmd.mode)
                        MODE_ALLOC:
                        begin
                            if (alloc_bad)
                            begin
                                res_next.status = ST_NOSPACE;
                                state_next      = S_FIN;
                            end
                        end
                        MODE_FREE:
                        begin
                            if (free_bad)
                            begin
                                res_next.status = ST_BADPTR;
                                state_next      = S_FIN;
                            end
                        end
                        MODE_REPORT:
                        begin
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                if (pos_reg >= END_G || (mode_reg == MODE_FREE && pos_reg > obj_reg))
                begin
                    case (mode_reg)
                        MODE_ALLOC:  res_next.status = ST_NOSPACE;
                        MODE_FREE:   res_next.status = ST_BADPTR;
                        default:
                        begin
                            res_next.used_bytes  = bytes_b[11:0];
                            res_next.used_blocks = cnt_w[9:0];
                        end
                    endcase
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                pos_next   = adv_pos;
                state_next = S_RD;
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (!h_used && h_sz >= need_reg)
                        begin
                            res_next.granted_offset = grant_b[11:0];
                            wa2_next = pos_reg[GW-1:0];
                            if (h_sz >= need_reg + PW'(2))
                            begin
                                wa1_next   = split_pos[GW-1:0];
                                wd1_next   = {split_sz[GW-1:0], 1'b0};
                                wd2_next   = {need_reg[GW-1:0], 1'b1};
                                state_next = S_WR1;
                            end
                            else
                            begin
                                wd2_next   = {h_sz[GW-1:0], 1'b1};
                                state_next = S_WR2;
                            end
                        end
                    end
                    MODE_FREE:
                    begin
                        if (pos_reg == obj_reg)
                        begin
                            if (!h_used)
                            begin
                                res_next.status = ST_BADPTR;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                wa2_next = prev_free_reg ? prev_pos_reg : pos_reg[GW-1:0];
                                acc_next = base_acc;
                                wd2_next = {base_acc[GW-1:0], 1'b0};
                                // look at the following block for a merge
                                state_next = (adv_pos < END_G) ? S_RDN : S_WR2;
                            end
                        end
                        else
                        begin
                            prev_free_next = !h_used;
                            prev_pos_next  = pos_reg[GW-1:0];
                            prev_sz_next   = h_sz[GW-1:0];
                        end
                    end
                    default:
                    begin
                        if (h_used)
                        begin
                            sum_next = sum_reg + h_sz;
                            cnt_next = cnt_reg + PW'(1);
                        end
                    end
                endcase
            end

            S_RDN:
            begin
                rd_en      = 1'b1;
                state_next = S_EVN;
            end

            S_EVN:
            begin
                if (!h_used)
                begin
                    acc_next = acc_reg + PW'(1) + h_sz;
                    wd2_next = {acc_next[GW-1:0], 1'b0};
                end
                state_next = S_WR2;
            end

            S_WR1:
            begin
                wr_en      = 1'b1;
                wr_addr    = wa1_reg;
                wr_data    = wd1_reg;
                state_next = S_WR2;
            end

            S_WR2:
            begin
                wr_en      = 1'b1;
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    status.done = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en && wr_addr == '0)
        begin
            init_next = 1'b0;
        end
        zero_hit_next = rd_en && (rd_addr == '0) && init_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            init_reg     <= 1'b1;
            zero_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            init_reg     <= init_next;
            zero_hit_reg <= zero_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        pos_reg       <= pos_next;
        need_reg      <= need_next;
        obj_reg       <= obj_next;
        prev_free_reg <= prev_free_next;
        prev_pos_reg  <= prev_pos_next;
        prev_sz_reg   <= prev_sz_next;
        acc_reg       <= acc_next;
        sum_reg       <= sum_next;
        cnt_reg       <= cnt_next;
        wa1_reg       <= wa1_next;
        wd1_reg       <= wd1_next;
        wa2_reg       <= wa2_next;
        wd2_reg       <= wd2_next;
        res_reg       <= res_next;
    end

    assign result = res_reg;

`include "first_fit_heap_allocator_assert.svh"

    `FFHA_ASSERT_NOW(a_wr_state, wr_en, state_reg == S_WR1 || state_reg == S_WR2, "write outside write state")
    `FFHA_ASSERT_NOW(a_rd_range, state_reg == S_EVAL, pos_reg < END_G, "header read past heap end")
    `FFHA_ASSERT_NEXT(a_done_once, status.done, state_reg == S_IDLE && !status.done, "result given twice")
    `FFHA_ASSERT_NEXT(a_init_sticky, !init_reg, !init_reg, "reset block came back")

endmodule

// ----- sv/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit allocator over an implicit list of block headers kept in ram
// ----------------------------------------------------------------------------
//  channel   dir   word    handshake
//  req       in    req_t   req_valid / req_stall
//  rsp       out   rsp_t   rsp_valid / rsp_stall
//
// an item walks the block headers, one read each, then does the merge read,
// the writes and the result: a block spans at least two granules, so at
// most about HEAP_BYTES/16 headers are walked before the result
// the single header ram port pair, one read per visited block, sets the rate
// one item at a time; the next word is taken while the last result waits
// reset needs no clearing pass: the first header reads as one free block
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  logic req_valid,
    output logic req_stall,
    output rsp_t rsp,
    output logic rsp_valid,
    input  logic rsp_stall
);

    localparam int GRANULES = HEAP_BYTES / 8;
    localparam int GW = $clog2(GRANULES);
    localparam int EW = GW + 1;

    ctrl_status_t  st;
    rsp_t          result;
    logic          out_free;
    logic          rd_en;
    logic [GW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          wr_en;
    logic [GW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg;

    assign req_stall = !st.idle;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    ffha_ctrl #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (req_valid && st.idle),
        .cmd     (req),
        .out_free(out_free),
        .status  (st),
        .result  (result),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ffha_ram #(
        .DATA_W(EW),
        .DEPTH (GRANULES)
    ) u_hdr_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (st.done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st.done)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- dv/first_fit_heap_allocator_test.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_test
// checks allocate, free with merging and report against a heap model in
// the testbench, with random idle cycles on both channels and long stalls
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_test
    import ffha_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_BYTES = 4096;
    localparam int GRANULES = HEAP_BYTES / 8;
    localparam int HEAP_END = GRANULES * 8;
    localparam int HDR = 8;
    localparam int MIN_SPLIT = 16;
    localparam int DRAIN_CYCLES = 2 * GRANULES + 20;
    localparam int CYCLE_LIMIT = 4000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    req_t req = '0;
    logic req_valid = 1'b0;
    logic req_stall;
    rsp_t rsp;
    logic rsp_valid;
    logic rsp_stall = 1'b0;

    first_fit_heap_allocator #(.HEAP_BYTES(HEAP_BYTES)) dut (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_stall(req_stall), .rsp(rsp), .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall)
    );

    always #10 clk = ~clk;

    // heap model: size with allocated mark in bit 0, per granule
    int unsigned heap_hdr [GRANULES];
    req_t pending_words [$];
    rsp_t expected_rsp [$];
    int unsigned live_offsets [$];
    int errors = 0;
    int cycles = 0;
    int accepted = 0;
    int checked = 0;
    int n_alloc_ok = 0;
    int n_merges = 0;
    bit no_idle = 1'b0;
    bit hold_rsp = 1'b0;
    int hold_cycles = 0;

    // stall as seen at the last rising edge
    logic req_stall_at_edge = 1'b1;

    function automatic rsp_t heap_step(req_t w);
        rsp_t r;
        int unsigned need, pos, h, sz, obj, nxt, prev_pos, off;
        bit prev_free;
        r = '0;
        if (w.mode == MODE_ALLOC)
        begin
            need = (int'(w.request_bytes) + 7) & ~7;
            r.status = ST_NOSPACE;
            if (w.request_bytes != 0 && need + HDR <= HEAP_END)
            begin
                pos = 0;
                while (pos < HEAP_END)
                begin
                    h = heap_hdr[pos >> 3];
                    sz = h & ~7;
                    if (!h[0] && sz >= need)
                    begin
                        if (sz >= need + MIN_SPLIT)
                        begin
                            heap_hdr[(pos + HDR + need) >> 3] = sz - HDR - need;
                            sz = need;
                        end
                        heap_hdr[pos >> 3] = sz | 1;
                        r.status = ST_OK;
                        r.granted_offset = 12'(pos + HDR);
                        live_offsets.push_back(pos + HDR);
                        n_alloc_ok++;
                        break;
                    end
                    pos += HDR + sz;
                end
            end
        end
        else if (w.mode == MODE_FREE)
        begin
            off = w.block_offset;
            r.status = ST_BADPTR;
            if (off >= HDR && off - HDR < HEAP_END)
            begin
                obj = off - HDR;
                pos = 0;
                prev_free = 1'b0;
                prev_pos = 0;
                while (pos < HEAP_END && pos <= obj)
                begin
                    h = heap_hdr[pos >> 3];
                    sz = h & ~7;
                    if (pos == obj)
                    begin
                        if (h[0])
                        begin
                            nxt = pos + HDR + sz;
                            r.status = ST_OK;
                            if (nxt < HEAP_END && !heap_hdr[nxt >> 3][0])
                            begin
                                sz += HDR + (heap_hdr[nxt >> 3] & ~7);
                                n_merges++;
                            end
                            if (prev_free)
                            begin
                                heap_hdr[prev_pos >> 3] =
                                    (heap_hdr[prev_pos >> 3] & ~7) + HDR + sz;
                                n_merges++;
                            end
                            else
                            begin
                                heap_hdr[pos >> 3] = sz;
                            end
                            foreach (live_offsets[i])
                            begin
                                if (live_offsets[i] == off)
                                begin
                                    live_offsets.delete(i);
                                    break;
                                end
                            end
                        end
                        break;
                    end
                    prev_free = !h[0];
                    prev_pos = pos;
                    pos += HDR + sz;
                end
            end
        end
        else if (w.mode == MODE_REPORT)
        begin
            int unsigned bytes, blocks;
            bytes = 0;
            blocks = 0;
            pos = 0;
            while (pos < HEAP_END)
            begin
                h = heap_hdr[pos >> 3];
                sz = h & ~7;
                if (h[0])
                begin
                    bytes += sz;
                    blocks++;
                end
                pos += HDR + sz;
            end
            r.used_bytes = 12'(bytes);
            r.used_blocks = 10'(blocks);
        end
        return r;
    endfunction

    function automatic req_t make_word(logic [1:0] m, int unsigned rb, int unsigned bo);
        req_t w;
        w.mode = m;
        w.request_bytes = 16'(rb);
        w.block_offset = 16'(bo);
        return w;
    endfunction

    // the model runs as each word is accepted
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && req_valid && !req_stall)
        begin
            expected_rsp.push_back(heap_step(req));
            accepted <= accepted + 1;
        end
    end

    // words are fed at the falling edge; a held word is not changed
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || !req_stall_at_edge)
            begin
                if (pending_words.size() > 0 &&
                    (no_idle || $urandom_range(99) >= 19))
                begin
                    req <= pending_words.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) req_stall_at_edge <= req_stall;

    // receiver stall, with a long hold-off when asked
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                hold_cycles <= hold_cycles + 1;
            end
            else
            begin
                rsp_stall <= !no_idle && ($urandom_range(99) < 19);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                rsp_t e;
                e = expected_rsp.pop_front();
                checked++;
                if (rsp.status !== e.status)
                begin
                    $error("status: expected %0d got %0d", e.status, rsp.status);
                    errors++;
                end
                if (rsp.granted_offset !== e.granted_offset)
                begin
                    $error("granted_offset: expected %0d got %0d",
                           e.granted_offset, rsp.granted_offset);
                    errors++;
                end
                if (rsp.used_bytes !== e.used_bytes)
                begin
                    $error("used_bytes: expected %0d got %0d",
                           e.used_bytes, rsp.used_bytes);
                    errors++;
                end
                if (rsp.used_blocks !== e.used_blocks)
                begin
                    $error("used_blocks: expected %0d got %0d",
                           e.used_blocks, rsp.used_blocks);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic wait_queue_empty();
        while (pending_words.size() > 0 || req_valid) @(posedge clk);
    endtask

    task automatic wait_results();
        wait_queue_empty();
        while (expected_rsp.size() > 0) @(posedge clk);
    endtask

    // pick a random free target: mostly live blocks, sometimes junk
    function automatic int unsigned free_target();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 75 && live_offsets.size() > 0)
            return live_offsets[$urandom_range(live_offsets.size() - 1)];
        else if (k < 85 && live_offsets.size() > 0)
            return live_offsets[$urandom_range(live_offsets.size() - 1)]
                   + 8 * $urandom_range(1, 3);
        else
            return $urandom_range(65535);
    endfunction

    initial
    begin
        int unsigned x, rb;
        heap_hdr = '{default: 0};
        heap_hdr[0] = HEAP_END - HDR;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes and every special case
        pending_words.push_back(make_word(MODE_REPORT, 0, 0));
        pending_words.push_back(make_word(MODE_ALLOC, 0, 0));
        pending_words.push_back(make_word(MODE_ALLOC, 65535, 0));
        pending_words.push_back(make_word(MODE_ALLOC, HEAP_END - 7, 0));
        pending_words.push_back(make_word(MODE_ALLOC, 1, 0));
        pending_words.push_back(make_word(MODE_ALLOC, 16, 0));
        pending_words.push_back(make_word(MODE_ALLOC, 17, 0));
        pending_words.push_back(make_word(MODE_REPORT, 0, 0));
        pending_words.push_back(make_word(MODE_FREE, 0, 0));
        pending_words.push_back(make_word(MODE_FREE, 0, 65535));
        pending_words.push_back(make_word(MODE_FREE, 0, 12));
        pending_words.push_back(make_word(MODE_FREE, 0, 24));
        pending_words.push_back(make_word(MODE_FREE, 0, 8));
        pending_words.push_back(make_word(MODE_FREE, 0, 8));
        pending_words.push_back(make_word(MODE_FREE, 0, 40));
        pending_words.push_back(make_word(MODE_FREE, 0, 24));
        pending_words.push_back(make_word(2'd3, 16'hffff, 16'hffff));
        pending_words.push_back(make_word(MODE_ALLOC, HEAP_END - 8, 0));
        pending_words.push_back(make_word(MODE_ALLOC, 8, 0));
        pending_words.push_back(make_word(MODE_REPORT, 0, 0));
        pending_words.push_back(make_word(MODE_FREE, 0, 8));
        pending_words.push_back(make_word(MODE_REPORT, 16'hffff, 16'hffff));
        wait_results();

        // random: free targets are chosen once the model has caught up
        for (int i = 0; i < 900; i++)
        begin
            if (i == 150) no_idle = 1'b1;
            if (i == 300) no_idle = 1'b0;
            if (i == 400)
            begin
                // receiver holds off so the block fills and stalls its input
                wait_results();
                hold_rsp = 1'b1;
                for (int j = 0; j < 8; j++)
                begin
                    pending_words.push_back(make_word(MODE_ALLOC,
                                                      $urandom_range(1, 64), 0));
                end
                while (hold_cycles < 600) @(posedge clk);
                hold_rsp = 1'b0;
            end
            if (i == 600) wait_results();   // sender pauses until all results are back
            x = $urandom_range(99);
            if (x < 45)
            begin
                rb = ($urandom_range(9) == 0) ? $urandom_range(65535)
                                               : $urandom_range(1, 200);
                pending_words.push_back(make_word(MODE_ALLOC, rb, $urandom_range(65535)));
            end
            else if (x < 85)
            begin
                wait_results();
                pending_words.push_back(make_word(MODE_FREE, $urandom_range(65535),
                                                  free_target()));
            end
            else if (x < 97)
            begin
                pending_words.push_back(make_word(MODE_REPORT, $urandom_range(65535),
                                                  $urandom_range(65535)));
            end
            else
            begin
                pending_words.push_back(make_word(2'd3, $urandom_range(65535),
                                                  $urandom_range(65535)));
            end
        end
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words accepted, %0d results checked", accepted, checked);
        $display("%0d successful allocations, %0d neighbor merges", n_alloc_ok, n_merges);
        if (errors == 0 && expected_rsp.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
